### src/qtgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtgr_pkg: shared types and codes of the quarter-turn grid rotator
// Field widths, request codes and direction symbol codes.
// ----------------------------------------------------------------------------
package qtgr_pkg;

  localparam int REQ_W   = 2;
  localparam int COORD_W = 6;
  localparam int SYM_W   = 3;
  localparam int GRID_W  = 7;
  localparam int TURN_W  = 2;

  typedef logic [REQ_W-1:0]   req_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [GRID_W-1:0]  grid_t;
  typedef logic [TURN_W-1:0]  turns_t;

  localparam req_t REQ_TURN  = 2'd0;
  localparam req_t REQ_WRITE = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  localparam sym_t SYM_DOT   = 3'd0;
  localparam sym_t SYM_RIGHT = 3'd1;
  localparam sym_t SYM_DOWN  = 3'd4;

  localparam grid_t GRID_RESET = 7'd64;

endpackage

### src/qtgr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtgr_ifs: request and result channels of the quarter-turn grid rotator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qtgr_in_if;
  import qtgr_pkg::*;

  logic   valid;
  logic   ready;
  req_t   req_type;
  logic   turn_left;
  coord_t row;
  coord_t col;
  sym_t   symbol_in;

  modport source (output valid, output req_type, output turn_left, output row,
                  output col, output symbol_in, input ready);
  modport sink   (input valid, input req_type, input turn_left, input row,
                  input col, input symbol_in, output ready);
endinterface

interface qtgr_out_if;
  import qtgr_pkg::*;

  logic valid;
  logic ready;
  sym_t symbol_out;

  modport source (output valid, output symbol_out, input ready);
  modport sink   (input valid, input symbol_out, output ready);
endinterface

### src/qtgr_addr_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtgr_addr_map: position to tile address mapping
// Clamps the tile size, checks the position against it and maps the position
// back to the source cell for a given number of left quarter turns.
// ----------------------------------------------------------------------------
module qtgr_addr_map #(
  parameter int MAX_SIZE = 64,
  parameter int AW       = 12
) (
  input  qtgr_pkg::grid_t  grid_size,
  input  qtgr_pkg::turns_t turns,
  input  qtgr_pkg::coord_t row,
  input  qtgr_pkg::coord_t col,
  output logic             in_range,
  output logic [AW-1:0]    addr
);
  import qtgr_pkg::*;

  // The register can never ask for more than its own range.
  localparam grid_t SIZE_CAP = (MAX_SIZE > 127) ? grid_t'(127) : grid_t'(MAX_SIZE);

  grid_t n;
  grid_t r_ext;
  grid_t c_ext;
  grid_t r_mir;
  grid_t c_mir;
  grid_t src_a;
  grid_t src_b;

  always_comb begin
    if (grid_size == '0) begin
      n = grid_t'(1);
    end else if (grid_size > SIZE_CAP) begin
      n = SIZE_CAP;
    end else begin
      n = grid_size;
    end
  end

  assign r_ext    = {1'b0, row};
  assign c_ext    = {1'b0, col};
  assign in_range = (r_ext < n) && (c_ext < n);
  assign r_mir    = n - grid_t'(1) - r_ext;
  assign c_mir    = n - grid_t'(1) - c_ext;

  always_comb begin
    unique case (turns)
      2'd0: begin
        src_a = r_ext;
        src_b = c_ext;
      end
      2'd1: begin
        src_a = c_ext;
        src_b = r_mir;
      end
      2'd2: begin
        src_a = r_mir;
        src_b = c_mir;
      end
      default: begin
        src_a = c_mir;
        src_b = r_ext;
      end
    endcase
  end

  // Source coordinates stay below the size in use whenever in_range holds.
  assign addr = AW'(src_a) * AW'(MAX_SIZE) + AW'(src_b);

endmodule

### src/quarter_turn_grid_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_turn_grid_rotator: square tile of arrows viewed under quarter turns
// A read fetches into the stage-one registers and then moves into the result register.
// Throughput: one request per cycle while the result channel does not stall,
//   set by the single tile memory access (one write or one read) that each request makes.
// Reset clears the turn count, sets the size to 64 and empties the pipeline;
//   the tile memory keeps its contents and has no clearing pass.
// ----------------------------------------------------------------------------
module quarter_turn_grid_rotator #(
  parameter int MAX_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  qtgr_pkg::grid_t   cfg_wr_data,
  qtgr_in_if.sink           in_ch,
  qtgr_out_if.source        out_ch
);
  import qtgr_pkg::*;

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Turning an arrow k quarters counterclockwise walks the code ring
  // right, up, left, down. The dot and unused codes come out as a dot.
  function automatic sym_t turn_symbol(input sym_t sym, input turns_t k);
    turns_t pos;
    pos = turns_t'(sym - SYM_RIGHT) + k;
    if ((sym == SYM_DOT) || (sym > SYM_DOWN)) begin
      return SYM_DOT;
    end
    return sym_t'({1'b0, pos}) + SYM_RIGHT;
  endfunction

  // Control state.
  grid_t  grid_r,      grid_nxt;
  turns_t turns_r,     turns_nxt;
  logic   s1_valid_r,  s1_valid_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Payload state.
  logic   s1_oob_r;
  turns_t s1_turns_r;
  sym_t   rd_data_r;
  sym_t   out_sym_r,   out_sym_nxt;

  sym_t   tile_mem [DEPTH];

  logic          accept;
  logic          s2_free;
  logic          s1_move;
  logic          is_read;
  logic          is_write;
  logic          map_in_range;
  logic [AW-1:0] map_addr;
  turns_t        map_turns;
  sym_t          wr_sym;

  // The result register frees up when it is empty or its transfer completes;
  // stage one only ever holds read requests, so it moves whenever that is so.
  assign s2_free     = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s2_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_read     = accept && (in_ch.req_type == REQ_READ);
  assign is_write    = accept && (in_ch.req_type == REQ_WRITE);

  // Writes always address the unrotated tile, so they map with no turns.
  assign map_turns = (in_ch.req_type == REQ_READ) ? turns_r : '0;

  qtgr_addr_map #(
    .MAX_SIZE (MAX_SIZE),
    .AW       (AW)
  ) u_addr_map (
    .grid_size (grid_r),
    .turns     (map_turns),
    .row       (in_ch.row),
    .col       (in_ch.col),
    .in_range  (map_in_range),
    .addr      (map_addr)
  );

  // Codes beyond the down arrow are stored as a dot.
  assign wr_sym = (in_ch.symbol_in > SYM_DOWN) ? SYM_DOT : in_ch.symbol_in;

  always_comb begin
    grid_nxt = grid_r;
    if (cfg_wr_en) begin
      grid_nxt = cfg_wr_data;
    end
  end

  // The count runs mod 4, so a left and a right turn cancel.
  always_comb begin
    turns_nxt = turns_r;
    if (accept && (in_ch.req_type == REQ_TURN)) begin
      turns_nxt = in_ch.turn_left ? turns_r + turns_t'(1) : turns_r - turns_t'(1);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (is_read) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = s1_oob_r ? SYM_DOT : turn_symbol(rd_data_r, s1_turns_r);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r      <= GRID_RESET;
      turns_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      grid_r      <= grid_nxt;
      turns_r     <= turns_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sym_r <= out_sym_nxt;
    if (is_read) begin
      s1_oob_r   <= !map_in_range;
      s1_turns_r <= turns_r;
    end
  end

  // Single-port tile memory: a write request stores, a read request fetches
  // into the stage-one data register, which holds while the output stalls.
  always_ff @(posedge clk) begin
    if (is_write && map_in_range) begin
      tile_mem[map_addr] <= wr_sym;
    end
    if (is_read) begin
      rd_data_r <= tile_mem[map_addr];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.symbol_out = out_sym_r;

  // An empty stage one must always take a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("request side stalled with an empty pipeline");

  // Reset leaves both stages empty.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // A position outside the tile in use reads as a dot.
  a_oob_is_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_oob_r) |=> (out_ch.valid && (out_ch.symbol_out == SYM_DOT)))
    else $error("out-of-range read did not return a dot");

  // A left turn advances the count by one.
  a_left_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.req_type == REQ_TURN) && in_ch.turn_left)
      |=> (turns_r == turns_t'($past(turns_r) + turns_t'(1))))
    else $error("left turn did not advance the count");

endmodule

### bench/quarter_turn_grid_rotator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_turn_grid_rotator_test: self-checking bench of the grid rotator
// Streams turn, write and read requests through the request channel and checks
// every read result against a behavioral model of the rotated tile. The tile
// size moves through several settings, extremes among them, and both channels
// stall at random.
// ----------------------------------------------------------------------------
module quarter_turn_grid_rotator_test;
  import qtgr_pkg::*;

  localparam int MAX_SIZE        = 64;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 96;
  // Extra cycles after the last result so that requests that give no result
  // (turns, writes, unused codes) have left the two-stage pipeline.
  localparam int SETTLE_CYCLES   = 6;
  localparam int TIMEOUT_NS      = 5_000_000;

  // Arrow codes the package does not name.
  localparam sym_t SYM_UP   = 3'd2;
  localparam sym_t SYM_LEFT = 3'd3;
  // The request code that the block ignores.
  localparam req_t REQ_UNUSED = 2'd3;

  typedef struct {
    req_t   req;
    logic   turn_left;
    coord_t row;
    coord_t col;
    sym_t   symbol;
    bit     hold;     // present only once every pending read has answered
  } request_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  grid_t cfg_wr_data;

  qtgr_in_if  in_ch ();
  qtgr_out_if out_ch ();

  quarter_turn_grid_rotator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #10 clk = ~clk;

  // Requests waiting to be driven, filled by the sequence below.
  request_t pending_requests[$];
  request_t next_request;
  // Arrow codes that the outstanding reads must return, oldest first.
  sym_t expected_symbols[$];

  // Idle percentages of the request sender and the result receiver.
  int send_idle_pct;
  int recv_idle_pct;

  int errors;
  int reads_checked;
  int turns_seen;
  int writes_seen;
  int unused_seen;
  // Requests queued so far, used to size each random phase.
  int queued_count;

  // Model of the block as the accepted requests have left it.
  turns_t model_turns;
  grid_t  model_grid;
  sym_t   model_tile [0:MAX_SIZE*MAX_SIZE-1];

  // Generator copy of the state, advanced as requests are queued, so that a
  // read is never aimed at a source cell that holds nothing yet.
  turns_t gen_turns;
  int     gen_size;
  bit     gen_written [0:MAX_SIZE*MAX_SIZE-1];

  // Side length actually used: zero acts as one, oversize values clamp.
  function automatic int size_in_use(input grid_t g);
    if (g == 0) return 1;
    if (g > MAX_SIZE) return MAX_SIZE;
    return int'(g);
  endfunction

  // Undo k left turns: walk the viewed position back to the stored cell.
  task automatic source_cell(input int r, input int c, input int k, input int n,
                             output int a, output int b);
    int t;
    a = r;
    b = c;
    for (int i = 0; i < k; i++) begin
      t = a;
      a = b;
      b = n - 1 - t;
    end
  endtask

  // Each left turn moves an arrow a quarter counterclockwise; a dot stays.
  function automatic sym_t turned_arrow(input sym_t s, input int k);
    if (s < SYM_RIGHT || s > SYM_DOWN) return SYM_DOT;
    return sym_t'(((int'(s) - int'(SYM_RIGHT) + k) & 3) + int'(SYM_RIGHT));
  endfunction

  // Advance the model by one accepted request and record what a read returns.
  task automatic apply_request(input req_t req, input logic left, input coord_t row,
                               input coord_t col, input sym_t s);
    int n;
    int a;
    int b;
    n = size_in_use(model_grid);
    case (req)
      REQ_TURN: begin
        model_turns = left ? model_turns + turns_t'(1) : model_turns - turns_t'(1);
        turns_seen++;
      end
      REQ_WRITE: begin
        // Writes outside the tile in use are dropped; bad codes store a dot.
        if (row < n && col < n) begin
          model_tile[row*MAX_SIZE+col] = (s > SYM_DOWN) ? SYM_DOT : s;
        end
        writes_seen++;
      end
      REQ_READ: begin
        if (row >= n || col >= n) begin
          expected_symbols.insert(expected_symbols.size(), SYM_DOT);
        end else begin
          source_cell(row, col, model_turns, n, a, b);
          expected_symbols.insert(expected_symbols.size(),
                                  turned_arrow(model_tile[a*MAX_SIZE+b], model_turns));
        end
      end
      default: unused_seen++;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Driver: offers the next queued request whenever the channel is free and
  // the sender does not idle; the model sees each request as it transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.req_type, in_ch.turn_left, in_ch.row, in_ch.col,
                      in_ch.symbol_in);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!pending_requests[0].hold || expected_symbols.size() == 0)) begin
          next_request = pending_requests.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.req_type  <= next_request.req;
          in_ch.turn_left <= next_request.turn_left;
          in_ch.row       <= next_request.row;
          in_ch.col       <= next_request.col;
          in_ch.symbol_in <= next_request.symbol;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is matched against the oldest expected arrow.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no read outstanding",
                                    out_ch.symbol_out));
        end else begin
          if (out_ch.symbol_out !== expected_symbols[0]) begin
            report_mismatch($sformatf("read %0d: symbol_out %0d, expected %0d",
                                      reads_checked, out_ch.symbol_out,
                                      expected_symbols[0]));
          end
          void'(expected_symbols.pop_front());
        end
        reads_checked++;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Queue one request and keep the generator copy of the state in step.
  task automatic queue_request(input req_t req, input logic left, input int row,
                               input int col, input sym_t s, input bit hold);
    request_t item;
    item.req       = req;
    item.turn_left = left;
    item.row       = coord_t'(row);
    item.col       = coord_t'(col);
    item.symbol    = s;
    item.hold      = hold;
    if (req == REQ_TURN) begin
      gen_turns = left ? gen_turns + turns_t'(1) : gen_turns - turns_t'(1);
    end else if (req == REQ_WRITE && row < gen_size && col < gen_size) begin
      gen_written[row*MAX_SIZE+col] = 1'b1;
    end
    pending_requests.insert(pending_requests.size(), item);
    queued_count++;
  endtask

  // A read inside the tile whose source cell is still empty first gets a
  // write of a random code to that source cell.
  task automatic queue_read(input int row, input int col, input bit hold);
    int a;
    int b;
    if (row < gen_size && col < gen_size) begin
      source_cell(row, col, gen_turns, gen_size, a, b);
      if (!gen_written[a*MAX_SIZE+b]) begin
        queue_request(REQ_WRITE, 1'b0, a, b, sym_t'($urandom_range(7)), 1'b0);
      end
    end
    queue_request(REQ_READ, 1'b0, row, col, SYM_DOT, hold);
  endtask

  task automatic queue_write(input int row, input int col, input sym_t s);
    queue_request(REQ_WRITE, 1'b0, row, col, s, 1'b0);
  endtask

  // Mostly inside the tile in use, sometimes anywhere in the coordinate range.
  function automatic int random_coord();
    if ($urandom_range(9) == 0) return $urandom_range(MAX_SIZE - 1);
    return $urandom_range(gen_size - 1);
  endfunction

  function automatic sym_t random_symbol();
    if ($urandom_range(99) < 12) return sym_t'($urandom_range(7, 5));
    return sym_t'($urandom_range(4));
  endfunction

  // Wait until nothing is queued, offered or outstanding, then let the
  // pipeline empty out of requests that give no result.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_symbols.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Size register write, only ever issued while the block is idle.
  task automatic write_grid_size(input grid_t g);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_grid = g;
    gen_size   = size_in_use(g);
    @(negedge clk);
  endtask

  grid_t phase_sizes [0:NUM_PHASES-1];

  initial begin
    int sel;
    bit hold;
    int phase_end;

    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_TURN;
    in_ch.turn_left = 1'b0;
    in_ch.row       = '0;
    in_ch.col       = '0;
    in_ch.symbol_in = SYM_DOT;
    out_ch.ready    = 1'b0;
    errors          = 0;
    reads_checked   = 0;
    turns_seen      = 0;
    writes_seen     = 0;
    unused_seen     = 0;
    queued_count    = 0;
    model_turns     = '0;
    model_grid      = GRID_RESET;
    gen_turns       = '0;
    gen_size        = size_in_use(GRID_RESET);
    send_idle_pct   = 11;
    recv_idle_pct   = 57;
    for (int i = 0; i < MAX_SIZE*MAX_SIZE; i++) begin
      model_tile[i]  = SYM_DOT;
      gen_written[i] = 1'b0;
    end

    // Zero acts as one and 127 clamps to the full tile; the rest are ordinary.
    phase_sizes = '{7'd0, 7'd127, 7'd1, 7'd2, 7'd5, 7'd64, 7'd3, 7'd17,
                    7'd63, 7'd8, 7'd33, 7'd4};
    phase_sizes[NUM_PHASES-1] = grid_t'($urandom_range(63, 2));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on the full tile: the four corners, every arrow, bad
    // codes, the unused request, and reads under every net turn count,
    // including a left and right turn that cancel.
    write_grid_size(7'd64);
    queue_write(0, 0, SYM_RIGHT);
    queue_write(63, 63, SYM_DOWN);
    queue_write(0, 63, SYM_UP);
    queue_write(63, 0, SYM_LEFT);
    queue_write(10, 20, 3'd7);
    queue_write(21, 42, 3'd5);
    queue_read(0, 0, 1'b0);
    queue_read(63, 63, 1'b0);
    queue_read(10, 20, 1'b0);
    queue_request(REQ_UNUSED, 1'b1, 63, 63, 3'd7, 1'b0);
    queue_request(REQ_TURN, 1'b1, 0, 0, SYM_DOT, 1'b0);
    // A write after a turn still lands on the unrotated tile.
    queue_write(42, 21, SYM_DOT);
    queue_read(0, 0, 1'b0);
    queue_read(63, 63, 1'b0);
    queue_read(0, 63, 1'b0);
    queue_request(REQ_TURN, 1'b1, 0, 0, SYM_DOT, 1'b0);
    queue_read(0, 0, 1'b0);
    queue_request(REQ_TURN, 1'b1, 0, 0, SYM_DOT, 1'b0);
    queue_read(0, 0, 1'b0);
    queue_request(REQ_TURN, 1'b0, 0, 0, SYM_DOT, 1'b0);
    queue_request(REQ_TURN, 1'b1, 0, 0, SYM_DOT, 1'b0);
    queue_read(63, 0, 1'b0);
    queue_request(REQ_TURN, 1'b1, 0, 0, SYM_DOT, 1'b0);
    queue_read(21, 42, 1'b0);

    // Random part. Each phase starts with a new size while the turn count
    // and the tile carry over. The idle pattern changes every four phases.
    // A phase ends once it has queued its share of requests, the writes that
    // prepare empty source cells included.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_grid_size(phase_sizes[p]);
      if (p < 4) begin
        send_idle_pct = 11;
        recv_idle_pct = 57;
      end else if (p < 8) begin
        send_idle_pct = 57;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_end = queued_count + ITEMS_PER_PHASE;
      for (int i = 0; queued_count < phase_end; i++) begin
        sel  = $urandom_range(99);
        // Now and then the sender holds back until every read has answered.
        hold = (p == 1 && i == ITEMS_PER_PHASE / 4) || ($urandom_range(63) == 0);
        if (sel < 18) begin
          queue_request(REQ_TURN, logic'($urandom_range(1)), $urandom_range(63),
                        $urandom_range(63), sym_t'($urandom_range(7)), hold);
        end else if (sel < 52) begin
          queue_request(REQ_WRITE, logic'($urandom_range(1)), random_coord(),
                        random_coord(), random_symbol(), hold);
        end else if (sel < 95) begin
          queue_read(random_coord(), random_coord(), hold);
        end else begin
          queue_request(REQ_UNUSED, logic'($urandom_range(1)), $urandom_range(63),
                        $urandom_range(63), sym_t'($urandom_range(7)), hold);
        end
      end
    end

    wait_idle();
    if (expected_symbols.size() != 0) begin
      report_mismatch($sformatf("%0d reads never answered", expected_symbols.size()));
    end

    $display("Covered %0d turns, %0d writes and %0d unused requests; %0d reads checked.",
             turns_seen, writes_seen, unused_seen, reads_checked);
    $display("Tile sizes from 0 (as 1) to 127 (as 64) over %0d phases, %0d mismatches.",
             NUM_PHASES, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
src/qtgr_pkg.sv
src/qtgr_ifs.sv
src/qtgr_addr_map.sv
src/quarter_turn_grid_rotator.sv
bench/quarter_turn_grid_rotator_test.sv
